// ===== src/crfp_pkg.sv =====
// Package for the circle ring fill painter: register map, region codes,
// configuration and the inter-stage word type. Used by every module of the block.

package crfp_pkg;

	// Largest image side; pixels at or beyond it pass unchanged
	localparam int MAX_DIM = 4096;
	localparam logic [14:0] MAX_DIM_V = 15'(MAX_DIM);

	localparam int ADDR_W = 5;

	// Register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_CENTER_COL     = 3'd0;
	localparam logic [2:0] REG_CENTER_ROW     = 3'd1;
	localparam logic [2:0] REG_RING_RADIUS    = 3'd2;
	localparam logic [2:0] REG_RING_THICKNESS = 3'd3;
	localparam logic [2:0] REG_FILL_ENABLE    = 3'd4;
	localparam logic [2:0] REG_LINE_RGB       = 3'd5;
	localparam logic [2:0] REG_FILL_RGB       = 3'd6;

	// Region codes reported with each painted word
	localparam logic [1:0] REGION_NONE = 2'd0;
	localparam logic [1:0] REGION_RING = 2'd1;
	localparam logic [1:0] REGION_FILL = 2'd2;

	typedef struct packed {
		logic signed [15:0] center_col;
		logic signed [15:0] center_row;
		logic [13:0]        ring_radius;
		logic [13:0]        ring_thickness;
		logic               fill_enable;
		logic [23:0]        line_rgb;
		logic [23:0]        fill_rgb;
	} cfg_t;

	// Word leaving the squaring stages
	typedef struct packed {
		logic [31:0] sq_x;
		logic [31:0] sq_y;
		logic [27:0] inner_sq;
		logic [29:0] outer_sq;
		logic        in_image;
		logic [23:0] rgb;
	} dist_t;

endpackage

// ===== src/crfp_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on crfp_pkg for the register map and cfg_t.

module crfp_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [crfp_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output crfp_pkg::cfg_t               cfg
);
	import crfp_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_col     <= '0;
			cfg_q.center_row     <= '0;
			cfg_q.ring_radius    <= 14'd1;
			cfg_q.ring_thickness <= 14'd1;
			cfg_q.fill_enable    <= 1'b0;
			cfg_q.line_rgb       <= '0;
			cfg_q.fill_rgb       <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_CENTER_COL:     cfg_q.center_col     <= pwdata[15:0];
				REG_CENTER_ROW:     cfg_q.center_row     <= pwdata[15:0];
				REG_RING_RADIUS:    cfg_q.ring_radius    <= pwdata[13:0];
				REG_RING_THICKNESS: cfg_q.ring_thickness <= pwdata[13:0];
				REG_FILL_ENABLE:    cfg_q.fill_enable    <= pwdata[0];
				REG_LINE_RGB:       cfg_q.line_rgb       <= pwdata[23:0];
				REG_FILL_RGB:       cfg_q.fill_rgb       <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CENTER_COL:     prdata = {16'd0, cfg_q.center_col};
			REG_CENTER_ROW:     prdata = {16'd0, cfg_q.center_row};
			REG_RING_RADIUS:    prdata = {18'd0, cfg_q.ring_radius};
			REG_RING_THICKNESS: prdata = {18'd0, cfg_q.ring_thickness};
			REG_FILL_ENABLE:    prdata = {31'd0, cfg_q.fill_enable};
			REG_LINE_RGB:       prdata = {8'd0, cfg_q.line_rgb};
			REG_FILL_RGB:       prdata = {8'd0, cfg_q.fill_rgb};
			default:            prdata = '0;
		endcase
	end

endmodule

// ===== src/crfp_dist.sv =====
// Offset and squaring stages (s1, s2): distance components, ring bounds,
// and their squares. Depends on crfp_pkg for cfg_t and dist_t.

module crfp_dist (
	input  logic             clk,
	input  logic             arst_n,
	input  crfp_pkg::cfg_t   cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [11:0]      pix_col,
	input  logic [11:0]      pix_row,
	input  logic [7:0]       in_red,
	input  logic [7:0]       in_green,
	input  logic [7:0]       in_blue,
	output logic             dist_valid,
	input  logic             dist_stall,
	output crfp_pkg::dist_t  dist_word
);
	import crfp_pkg::*;

	logic               v_s1, v_s2;
	logic               rdy_s1, rdy_s2;
	logic signed [16:0] dx_s1, dy_s1;
	logic [13:0]        inner_s1;
	logic [14:0]        outer_s1;
	logic               in_image_s1;
	logic [23:0]        rgb_s1;
	dist_t              word_s2;

	logic signed [16:0] dx_c, dy_c;
	logic [12:0]        half_c;
	logic signed [14:0] inner_c;
	logic [14:0]        outer_c;
	logic signed [33:0] sqx_c, sqy_c;
	logic [27:0]        isq_c;
	logic [29:0]        osq_c;

	assign rdy_s2   = !v_s2 || !dist_stall;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_comb begin
		dx_c    = $signed({5'd0, pix_col}) - $signed({cfg.center_col[15], cfg.center_col});
		dy_c    = $signed({5'd0, pix_row}) - $signed({cfg.center_row[15], cfg.center_row});
		half_c  = cfg.ring_thickness[13:1];
		inner_c = $signed({1'b0, cfg.ring_radius}) - $signed({2'b00, half_c});
		// one past the outer edge, so the ring test is d2 < outer_sq
		outer_c = {1'b0, cfg.ring_radius} + {2'b00, half_c} + 15'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			dx_s1       <= dx_c;
			dy_s1       <= dy_c;
			// clamp a non-positive inner edge to zero: no lower bound, no fill
			inner_s1    <= (inner_c > 15'sd0) ? inner_c[13:0] : 14'd0;
			outer_s1    <= outer_c;
			in_image_s1 <= (15'(pix_col) < MAX_DIM_V) && (15'(pix_row) < MAX_DIM_V);
			rgb_s1      <= {in_red, in_green, in_blue};
		end
	end

	always_comb begin
		sqx_c = dx_s1 * dx_s1;
		sqy_c = dy_s1 * dy_s1;
		isq_c = 28'(inner_s1) * 28'(inner_s1);
		osq_c = 30'(outer_s1) * 30'(outer_s1);
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			word_s2.sq_x     <= sqx_c[31:0];
			word_s2.sq_y     <= sqy_c[31:0];
			word_s2.inner_sq <= isq_c;
			word_s2.outer_sq <= osq_c;
			word_s2.in_image <= in_image_s1;
			word_s2.rgb      <= rgb_s1;
		end
	end

	assign dist_valid = v_s2;
	assign dist_word  = word_s2;

endmodule

// ===== src/crfp_paint.sv =====
// Sum and classify stages (s3, s4): squared distance, ring/fill test against
// squared bounds, colour select into the output register. Depends on crfp_pkg.

module crfp_paint (
	input  logic             clk,
	input  logic             arst_n,
	input  crfp_pkg::cfg_t   cfg,
	input  logic             dist_valid,
	output logic             dist_stall,
	input  crfp_pkg::dist_t  dist_word,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_red,
	output logic [7:0]       out_green,
	output logic [7:0]       out_blue,
	output logic [1:0]       region_code
);
	import crfp_pkg::*;

	logic        v_s3, v_s4;
	logic        rdy_s3, rdy_s4;
	logic [31:0] d2_s3;
	logic [27:0] inner_sq_s3;
	logic [29:0] outer_sq_s3;
	logic        in_image_s3;
	logic [23:0] rgb_s3;
	logic [23:0] rgb_s4;
	logic [1:0]  region_s4;

	logic        ring_c, fill_c;
	logic [1:0]  region_c;
	logic [23:0] rgb_c;

	assign rdy_s4     = !v_s4 || !out_stall;
	assign rdy_s3     = !v_s3 || rdy_s4;
	assign dist_stall = !rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s3) v_s3 <= dist_valid;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && dist_valid) begin
			d2_s3       <= dist_word.sq_x + dist_word.sq_y;
			inner_sq_s3 <= dist_word.inner_sq;
			outer_sq_s3 <= dist_word.outer_sq;
			in_image_s3 <= dist_word.in_image;
			rgb_s3      <= dist_word.rgb;
		end
	end

	// ring wins over fill; a zero inner square never fills
	always_comb begin
		ring_c = in_image_s3 && (d2_s3 >= 32'(inner_sq_s3)) && (d2_s3 < 32'(outer_sq_s3));
		fill_c = in_image_s3 && !ring_c && cfg.fill_enable && (d2_s3 < 32'(inner_sq_s3));
		priority if (ring_c) begin
			region_c = REGION_RING;
			rgb_c    = cfg.line_rgb;
		end else if (fill_c) begin
			region_c = REGION_FILL;
			rgb_c    = cfg.fill_rgb;
		end else begin
			region_c = REGION_NONE;
			rgb_c    = rgb_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			rgb_s4    <= rgb_c;
			region_s4 <= region_c;
		end
	end

	assign out_valid   = v_s4;
	assign out_red     = rgb_s4[23:16];
	assign out_green   = rgb_s4[15:8];
	assign out_blue    = rgb_s4[7:0];
	assign region_code = region_s4;

endmodule

// ===== src/circle_ring_fill_painter_unit.sv =====
// Circle ring fill painter: paints each streamed pixel with the ring colour
// when its floor distance from the centre lies within radius +/- thickness/2,
// with the fill colour inside the ring when fill is enabled, else passes it.
// Throughput is one pixel per clock while out_stall does not back up the
// pipeline; each pixel passes through the four-stage pipeline (offset,
// square, sum, classify) before it leaves with out_valid.
// The distance test compares squared distance against squared ring bounds,
// so no square root unit is present. Write registers only while no pixel is
// in flight. Depends on crfp_pkg, crfp_regs, crfp_dist and crfp_paint.

module circle_ring_fill_painter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [crfp_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [11:0]                  pix_col,
	input  logic [11:0]                  pix_row,
	input  logic [7:0]                   in_red,
	input  logic [7:0]                   in_green,
	input  logic [7:0]                   in_blue,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   out_red,
	output logic [7:0]                   out_green,
	output logic [7:0]                   out_blue,
	output logic [1:0]                   region_code
);
	import crfp_pkg::*;

	cfg_t  cfg;
	logic  dist_valid;
	logic  dist_stall;
	dist_t dist_word;

	crfp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crfp_dist u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pix_col    (pix_col),
		.pix_row    (pix_row),
		.in_red     (in_red),
		.in_green   (in_green),
		.in_blue    (in_blue),
		.dist_valid (dist_valid),
		.dist_stall (dist_stall),
		.dist_word  (dist_word)
	);

	crfp_paint u_paint (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.dist_valid  (dist_valid),
		.dist_stall  (dist_stall),
		.dist_word   (dist_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.region_code (region_code)
	);

endmodule

// ===== src/crfp_checker.sv =====
// Port-level checks for circle_ring_fill_painter_unit, attached by bind.
// Depends on crfp_pkg for the region codes.

module crfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pready,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic [1:0] region_code
);
	import crfp_pkg::*;

	// input backs up only when the pipeline is full behind a stalled output word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled output word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(region_code)))
		else $error("stalled output word changed or dropped");

	a_region: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (region_code == REGION_NONE || region_code == REGION_RING
			|| region_code == REGION_FILL))
		else $error("region_code out of range");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("out_valid high in reset");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind circle_ring_fill_painter_unit crfp_checker u_crfp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pready      (pready),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_red     (out_red),
	.out_green   (out_green),
	.out_blue    (out_blue),
	.region_code (region_code)
);

// ===== dv/crfp_painter_checker.sv =====
// Checker for the circle ring fill painter: follows register writes, predicts
// each painted word from the pixel accepted at the input and compares.
// Depends on crfp_pkg for the register map, region codes and cfg_t.

module crfp_painter_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [crfp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic                        pready,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [11:0]                 pix_col,
	input  logic [11:0]                 pix_row,
	input  logic [7:0]                  in_red,
	input  logic [7:0]                  in_green,
	input  logic [7:0]                  in_blue,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [7:0]                  out_red,
	input  logic [7:0]                  out_green,
	input  logic [7:0]                  out_blue,
	input  logic [1:0]                  region_code,
	output int                          fail_count,
	output int                          open_words
);
	timeunit 1ns;
	timeprecision 1ps;
	import crfp_pkg::*;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [1:0] region;
	} painted_t;

	cfg_t     circle;
	painted_t painted_q[$];
	int       n_reported = 0;

	// Words still owed at the end count as failures too
	assign fail_count = n_reported + open_words;

	function automatic longint floor_root(longint n);
		longint root;
		longint trial;
		root = 0;
		for (int b = 16; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= n)
				root = trial;
		end
		return root;
	endfunction

	function automatic painted_t paint_pixel(cfg_t c, logic [11:0] col, logic [11:0] row,
			logic [7:0] red, logic [7:0] green, logic [7:0] blue);
		painted_t p;
		longint   dx, dy, d_root, half, inner, outer;
		p.red    = red;
		p.green  = green;
		p.blue   = blue;
		p.region = REGION_NONE;
		if (col < MAX_DIM && row < MAX_DIM) begin
			dx     = longint'(col) - longint'(c.center_col);
			dy     = longint'(row) - longint'(c.center_row);
			d_root = floor_root(dx * dx + dy * dy);
			half   = longint'(c.ring_thickness >> 1);
			inner  = longint'(c.ring_radius) - half;
			outer  = longint'(c.ring_radius) + half;
			// ring wins over fill; a negative inner bound leaves no interior
			if (d_root >= inner && d_root <= outer) begin
				p.region = REGION_RING;
				{p.red, p.green, p.blue} = c.line_rgb;
			end else if (c.fill_enable && d_root < inner) begin
				p.region = REGION_FILL;
				{p.red, p.green, p.blue} = c.fill_rgb;
			end
		end
		return p;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		n_reported++;
		// keep the log short when the block is badly broken
		if (n_reported <= 100)
			$display("crfp check @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		painted_t want;
		if (!arst_n) begin
			circle                = '0;
			circle.ring_radius    = 14'd1;
			circle.ring_thickness = 14'd1;
			painted_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_CENTER_COL:     circle.center_col = pwdata[15:0];
					REG_CENTER_ROW:     circle.center_row = pwdata[15:0];
					REG_RING_RADIUS:    circle.ring_radius = pwdata[13:0];
					REG_RING_THICKNESS: circle.ring_thickness = pwdata[13:0];
					REG_FILL_ENABLE:    circle.fill_enable = pwdata[0];
					REG_LINE_RGB:       circle.line_rgb = pwdata[23:0];
					REG_FILL_RGB:       circle.fill_rgb = pwdata[23:0];
					default: ;
				endcase
			end
			// push before pop so a same-edge pass-through still lines up
			if (in_valid && !in_stall)
				painted_q.push_back(paint_pixel(circle, pix_col, pix_row,
					in_red, in_green, in_blue));
			if (out_valid && !out_stall) begin
				if (painted_q.size() == 0) begin
					report_mismatch("word with nothing pending, region", region_code, 0);
				end else begin
					want = painted_q.pop_front();
					if (out_red !== want.red)
						report_mismatch("out_red", out_red, want.red);
					if (out_green !== want.green)
						report_mismatch("out_green", out_green, want.green);
					if (out_blue !== want.blue)
						report_mismatch("out_blue", out_blue, want.blue);
					if (region_code !== want.region)
						report_mismatch("region_code", region_code, want.region);
				end
			end
		end
		open_words <= painted_q.size();
	end

endmodule

// ===== dv/tb_circle_ring_fill_painter_unit.sv =====
// Testbench top for circle_ring_fill_painter_unit: clock, reset, register
// writes, pixel stimulus with random idling, watchdog and verdict.
// Depends on crfp_pkg, the block and crfp_painter_checker.

module tb_circle_ring_fill_painter_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import crfp_pkg::*;

	localparam int         WATCHDOG_LIMIT = 4000;
	localparam int         LONG_HOLD      = 200;
	localparam int         END_PAD        = 16;
	localparam int         RANDOM_PHASES  = 6;
	localparam int         PHASE_ITEMS    = 75;
	localparam logic [2:0] REG_SPARE      = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	logic [11:0]       pix_col;
	logic [11:0]       pix_row;
	logic [7:0]        in_red;
	logic [7:0]        in_green;
	logic [7:0]        in_blue;
	logic              out_valid;
	logic              out_stall;
	logic [7:0]        out_red;
	logic [7:0]        out_green;
	logic [7:0]        out_blue;
	logic [1:0]        region_code;
	int                fail_count;
	int                open_words;

	// current circle, used only to aim pixels at the ring
	int cur_cx = 0;
	int cur_cy = 0;
	int cur_inner = 1;
	int cur_outer = 1;

	bit hold_req = 1'b0;
	int holds_started = 0;
	int idle_cycles = 0;

	always #2 clk = ~clk;

	circle_ring_fill_painter_unit u_top (.*);
	crfp_painter_checker u_check (.*);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_circle_ring_fill_painter_unit: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// output side: random stalls, long holds on request
	initial begin
		int pick;
		forever begin
			pick = $urandom_range(0, 99);
			if (hold_req) begin
				out_stall <= 1'b1;
				hold_req = 1'b0;
				holds_started++;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (pick < 40) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else if (pick < 70) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else if (pick < 92) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(8, 30)) @(posedge clk);
			end
		end
	end

	function automatic int pick_gap(bit bursty);
		int pick;
		pick = $urandom_range(0, 99);
		if (bursty || pick < 50)
			return 0;
		if (pick < 82)
			return $urandom_range(1, 3);
		if (pick < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// leaves in_valid high after the accept so back-to-back words need no toggle
	task automatic send_pixel(logic [11:0] col, logic [11:0] row,
			logic [7:0] red, logic [7:0] green, logic [7:0] blue, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pix_col  <= col;
		pix_row  <= row;
		in_red   <= red;
		in_green <= green;
		in_blue  <= blue;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (open_words != 0);
	endtask

	// psel and penable stay high between writes; the caller drops them
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
	endtask

	task automatic program_circle(int cx, int cy, int rad, int thk, bit fill_on,
			logic [23:0] line_c, logic [23:0] fill_c);
		write_reg(REG_CENTER_COL, {16'h0, cx[15:0]});
		write_reg(REG_CENTER_ROW, {16'h0, cy[15:0]});
		write_reg(REG_RING_RADIUS, {18'h0, rad[13:0]});
		write_reg(REG_RING_THICKNESS, {18'h0, thk[13:0]});
		write_reg(REG_FILL_ENABLE, {31'h0, fill_on});
		write_reg(REG_LINE_RGB, {8'h0, line_c});
		write_reg(REG_FILL_RGB, {8'h0, fill_c});
		// no register behind this index; the write must leave everything alone
		write_reg(REG_SPARE, $urandom);
		psel    <= 1'b0;
		penable <= 1'b0;
		cur_cx    = cx;
		cur_cy    = cy;
		cur_inner = rad - thk / 2;
		cur_outer = rad + thk / 2;
	endtask

	// mostly pixels near the ring or inside it, the rest anywhere in the image
	task automatic aim_pixel(output logic [11:0] col, output logic [11:0] row);
		int lo, t, dx, dy, px, py;
		if ($urandom_range(0, 9) < 3) begin
			col = 12'($urandom);
			row = 12'($urandom);
			return;
		end
		lo = cur_inner - 2;
		if (lo < 0 || $urandom_range(0, 3) == 0)
			lo = 0;
		t  = $urandom_range(lo, cur_outer + 2);
		dx = $urandom_range(0, t);
		dy = int'($floor($sqrt(real'(t) * t - real'(dx) * dx)));
		dy = dy + int'($urandom_range(0, 2)) - 1;
		if ($urandom_range(0, 1))
			dx = -dx;
		if ($urandom_range(0, 1))
			dy = -dy;
		px = cur_cx + dx;
		py = cur_cy + dy;
		if (px < 0 || px > MAX_DIM - 1 || py < 0 || py > MAX_DIM - 1) begin
			col = 12'($urandom);
			row = 12'($urandom);
		end else begin
			col = px[11:0];
			row = py[11:0];
		end
	endtask

	initial begin
		logic [11:0] col, row;
		int          cx, cy, rad, thk, pick, hold_mark, n_held;
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		in_valid <= 1'b0;
		pix_col  <= '0;
		pix_row  <= '0;
		in_red   <= '0;
		in_green <= '0;
		in_blue  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset circle: center at origin, radius 1, ring one pixel wide, no fill
		send_pixel(12'd0, 12'd0, 8'hFF, 8'h00, 8'hA5, pick_gap(0));
		send_pixel(12'd1, 12'd0, 8'h00, 8'hFF, 8'h5A, pick_gap(0));
		send_pixel(12'd1, 12'd1, 8'hA5, 8'h5A, 8'hFF, pick_gap(0));
		send_pixel(12'd2, 12'd0, 8'h5A, 8'hA5, 8'h00, pick_gap(0));
		send_pixel(12'd0, 12'd4095, 8'hFF, 8'hFF, 8'hFF, pick_gap(0));
		wait_drained();

		// ring 17..23 with fill; probe both edges and a truncated root
		program_circle(100, 80, 20, 6, 1'b1, 24'hFF0000, 24'h00FF00);
		send_pixel(12'd100, 12'd80, 8'h11, 8'h22, 8'h33, pick_gap(0));
		send_pixel(12'd116, 12'd80, 8'h44, 8'h55, 8'h66, pick_gap(0));
		send_pixel(12'd117, 12'd80, 8'h77, 8'h88, 8'h99, pick_gap(0));
		send_pixel(12'd112, 12'd96, 8'hAA, 8'hBB, 8'hCC, pick_gap(0));
		send_pixel(12'd123, 12'd86, 8'hDD, 8'hEE, 8'hFF, pick_gap(0));
		send_pixel(12'd124, 12'd80, 8'h01, 8'h02, 8'h03, pick_gap(0));
		send_pixel(12'd4095, 12'd4095, 8'hFE, 8'hFD, 8'hFC, pick_gap(0));
		send_pixel(12'd0, 12'd0, 8'h80, 8'h40, 8'h20, pick_gap(0));
		wait_drained();

		// zero radius and thickness: only the center pixel is ring
		program_circle(4095, 0, 0, 0, 1'b1, 24'h0000FF, 24'hFFFFFF);
		send_pixel(12'd4095, 12'd0, 8'h12, 8'h34, 8'h56, pick_gap(0));
		send_pixel(12'd4094, 12'd0, 8'h65, 8'h43, 8'h21, pick_gap(0));
		send_pixel(12'd4095, 12'd4095, 8'h0F, 8'hF0, 8'h3C, pick_gap(0));
		wait_drained();

		// thick ring reaching past the center: everything nearby is ring
		program_circle(2000, 2000, 5, 16383, 1'b1, 24'h123456, 24'hEDCBA9);
		send_pixel(12'd2000, 12'd2000, 8'h00, 8'h00, 8'h00, pick_gap(0));
		send_pixel(12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF, pick_gap(0));
		send_pixel(12'd4095, 12'd4095, 8'h5A, 8'h5A, 8'h5A, pick_gap(0));
		wait_drained();

		// center at the far corners of the signed range
		program_circle(-32768, 32767, 16383, 16382, 1'b1, 24'hFFFFFF, 24'hFFFFFF);
		send_pixel(12'd0, 12'd4095, 8'hC3, 8'h3C, 8'h99, pick_gap(0));
		send_pixel(12'd4095, 12'd0, 8'h66, 8'hC3, 8'h3C, pick_gap(0));
		wait_drained();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == RANDOM_PHASES - 1) begin
				// largest radius and thickness: the whole image falls in the interior
				program_circle(0, 0, 16383, 16383, 1'b1, 24'($urandom), 24'($urandom));
			end else begin
				if ($urandom_range(0, 3) == 0) begin
					cx = int'($signed(16'($urandom)));
					cy = int'($signed(16'($urandom)));
				end else begin
					cx = $urandom_range(0, MAX_DIM - 1);
					cy = $urandom_range(0, MAX_DIM - 1);
				end
				pick = $urandom_range(0, 99);
				if (pick < 60)
					rad = $urandom_range(1, 400);
				else if (pick < 85)
					rad = $urandom_range(0, 16383);
				else
					rad = (pick < 92) ? 16383 : $urandom_range(0, 1);
				pick = $urandom_range(0, 99);
				if (pick < 60)
					thk = $urandom_range(0, 20);
				else if (pick < 85)
					thk = $urandom_range(0, 400);
				else
					thk = (pick < 92) ? $urandom_range(16382, 16383) : $urandom_range(0, 1);
				program_circle(cx, cy, rad, thk, 1'($urandom_range(0, 1)),
					24'($urandom), 24'($urandom));
			end

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (phase == 1 && i == 10) begin
					// hold the output and keep offering until the hold has begun and the
					// block has backed up into its input
					hold_mark = holds_started;
					hold_req  = 1'b1;
					n_held    = 0;
					while (n_held < 24) begin
						aim_pixel(col, row);
						send_pixel(col, row, 8'($urandom), 8'($urandom), 8'($urandom), 0);
						if (holds_started != hold_mark)
							n_held++;
					end
				end
				if (phase == 3 && i == PHASE_ITEMS / 2)
					wait_drained();
				aim_pixel(col, row);
				send_pixel(col, row, 8'($urandom), 8'($urandom), 8'($urandom),
					pick_gap(phase == 2));
			end
			wait_drained();
		end

		repeat (END_PAD) @(posedge clk);
		if (fail_count == 0)
			$display("tb_circle_ring_fill_painter_unit: done, clean");
		else
			$display("tb_circle_ring_fill_painter_unit: done, errors");
		$finish;
	end

endmodule
